// ===== hdl/telemetry_poll_responder_scheduler_assert.svh =====
// Assertion macros for the telemetry poll responder.
// Included by tprs_dp; depends on nothing else.
`ifndef TELEMETRY_POLL_RESPONDER_SCHEDULER_ASSERT_SVH
`define TELEMETRY_POLL_RESPONDER_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define TPRS_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tprs invariant violated");
`define TPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tprs next-cycle check failed");
`else
`define TPRS_ASSERT_HOLDS(label, clk, rst_n, prop)
`define TPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tprs_pkg.sv =====
// Shared types, constants and the item period table of the poll responder.
// Used by tprs_ctrl, tprs_dp and the top level; no dependencies.
package tprs_pkg;

    localparam int ITEM_W      = 5;
    localparam int ITEM_SPACE  = 32;
    localparam int AVAIL_W     = 24;
    localparam int PERIOD_W    = 23;
    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 16;

    localparam logic [7:0] POLL_BYTE = 8'h7e;

    localparam logic [1:0] PH_POLL = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_ECHO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_SKIP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POLL,
        OP_ID,
        OP_ECHO,
        OP_SCAN
    } t_op;

    typedef struct packed {
        logic latch;
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] phase;
        logic       id_match;
        logic       scan_done;
        logic       out_free;
    } t_sts;

    function automatic logic [PERIOD_W-1:0] period_us(input logic [ITEM_W-1:0] idx);
        logic [PERIOD_W-1:0] p;
        case (idx)
            5'd0, 5'd1, 5'd2, 5'd13, 5'd14, 5'd15,
            5'd16, 5'd17, 5'd23:                    p = 23'd100000;
            5'd3:                                   p = 23'd300000;
            5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:     p = 23'd850000;
            5'd10, 5'd21:                           p = 23'd2000000;
            5'd11, 5'd22:                           p = 23'd1500000;
            5'd12:                                  p = 23'd600000;
            5'd18:                                  p = 23'd750000;
            5'd19:                                  p = 23'd200000;
            5'd20:                                  p = 23'd8000000;
            default:                                p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/telemetry_poll_responder_scheduler.sv =====
// Top level of the polled telemetry responder and item scheduler.
// Instantiates tprs_ctrl and tprs_dp; uses tprs_pkg.
//
//  port group  dir  beat moves
//  i_s_*       in   one received bus byte with time, mask and encode result
//  o_m_*       out  one response: send order, scheduled item, bus phase
//  i_cfg_*     in   register write: 0 sensor id, 1 echo skip, 2 min poll gap
//
// A poll reply that matches the id adds a serial scan of the item table,
// one item table entry per cycle, that stops at the first due item or the last entry.
// Synchronous active-low reset restores register defaults and clears all
// item stamps and rounds at once. A new beat is taken only when the prior
// one has finished; a stalled output holds the finished beat until taken.
module telemetry_poll_responder_scheduler import tprs_pkg::*; #(
    parameter int NUM_ITEMS = 24,
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // rx_byte[7:0], now_us[39:8], available_mask[63:40], value_ok[64],
    // frame_len[69:65], zero fill[71:70]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // send_valid[0], send_item[5:1], pending_valid[6], pending_item[11:7],
    // phase[13:12], zero fill[15:14]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    tprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tprs_dp #(
        .NUM_ITEMS (NUM_ITEMS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ===== hdl/tprs_ctrl.sv =====
// Sequencer of the poll responder: accepts a beat, issues one phase step,
// walks the item scan and hands the result to the output stage. Uses tprs_pkg.
module tprs_ctrl import tprs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        o_cmd.latch    = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: o_cmd.latch = i_s_tvalid;
            S_EXEC: begin
                unique case (i_sts.phase)
                    PH_ID:   o_cmd.op = OP_ID;
                    PH_ECHO: o_cmd.op = OP_ECHO;
                    default: o_cmd.op = OP_POLL;
                endcase
            end
            S_SCAN: o_cmd.op = OP_SCAN;
            S_DONE: o_cmd.load_out = i_sts.out_free;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_s_tvalid) r_state <= S_EXEC;
                S_EXEC: begin
                    if (i_sts.phase == PH_ID && i_sts.id_match) r_state <= S_SCAN;
                    else r_state <= S_DONE;
                end
                S_SCAN: if (i_sts.scan_done) r_state <= S_DONE;
                S_DONE: if (i_sts.out_free) r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/tprs_dp.sv =====
// Datapath of the poll responder: settings, bus phase, echo counter,
// item timestamps and rounds, serial scheduler scan and output register.
// Uses tprs_pkg and telemetry_poll_responder_scheduler_assert.svh.
`include "telemetry_poll_responder_scheduler_assert.svh"
module tprs_dp import tprs_pkg::*; #(
    parameter int NUM_ITEMS = 24,
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int IW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int CW = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ITEMS - 1);

    // settings
    logic [7:0]            r_sensor_id;
    logic                  r_echo_skip;
    logic [15:0]           r_min_gap;

    // control state
    logic [1:0]            r_phase;
    logic [7:0]            r_echo_left;
    logic [TIME_BITS-1:0]  r_last_poll;
    logic [ITEM_W-1:0]     r_pending_index;
    logic                  r_pending_flag;
    logic [15:0]           r_round;
    logic [TIME_BITS-1:0]  r_item_sent [NUM_ITEMS];
    logic [15:0]           r_item_round [NUM_ITEMS];
    logic [IW-1:0]         r_scan;
    logic                  r_send_valid;
    logic [ITEM_W-1:0]     r_send_item;
    logic                  r_m_tvalid;

    // latched beat and output payload
    logic [7:0]            r_rx_byte;
    logic [TIME_BITS-1:0]  r_now;
    logic [AVAIL_W-1:0]    r_avail;
    logic                  r_ok;
    logic [4:0]            r_flen;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    logic [TIME_BITS-1:0]  w_poll_el;
    logic                  w_poll_ok;
    logic [TIME_BITS-1:0]  w_scan_el;
    logic [ITEM_SPACE-1:0] w_avail_ext;
    logic [ITEM_W-1:0]     w_scan_idx;
    logic                  w_scan_hit;
    logic [8:0]            w_echo_sum;
    logic [7:0]            w_echo_sat;
    logic                  w_do_send;
    logic [7:0]            n_echo_left;
    logic [IW-1:0]         w_pend_addr;
    logic [ITEM_W-1:0]     w_pend_out;

    assign w_pend_addr = r_pending_index[IW-1:0];
    assign w_poll_el   = r_now - r_last_poll;
    assign w_poll_ok   = (r_rx_byte == POLL_BYTE) && (CW'(w_poll_el) > CW'(r_min_gap));

    assign w_scan_idx  = ITEM_W'(r_scan);
    assign w_avail_ext = ITEM_SPACE'(r_avail);
    assign w_scan_el   = r_now - r_item_sent[r_scan];
    assign w_scan_hit  = w_avail_ext[w_scan_idx] && (r_item_round[r_scan] != r_round) &&
                         (CW'(w_scan_el) > CW'(period_us(w_scan_idx)));

    assign w_echo_sum  = {1'b0, r_echo_left} + 9'(r_flen);
    assign w_echo_sat  = w_echo_sum[8] ? 8'hff : w_echo_sum[7:0];
    assign w_do_send   = r_pending_flag && r_ok;

    always_comb begin
        n_echo_left = r_echo_left;
        if (w_do_send) n_echo_left = r_echo_skip ? w_echo_sat : 8'd0;
    end

    assign w_pend_out = r_pending_flag ? r_pending_index : '0;

    assign o_sts.phase     = r_phase;
    assign o_sts.id_match  = (r_rx_byte == r_sensor_id);
    assign o_sts.scan_done = w_scan_hit || (r_scan == LAST_IDX);
    assign o_sts.out_free  = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_id     <= 8'd27;
            r_echo_skip     <= 1'b1;
            r_min_gap       <= 16'd10000;
            r_phase         <= PH_POLL;
            r_echo_left     <= '0;
            r_last_poll     <= '0;
            r_pending_index <= '0;
            r_pending_flag  <= 1'b0;
            r_round         <= 16'd1;
            r_scan          <= '0;
            r_send_valid    <= 1'b0;
            r_send_item     <= '0;
            r_m_tvalid      <= 1'b0;
            for (int i = 0; i < NUM_ITEMS; i++) begin
                r_item_sent[i]  <= '0;
                r_item_round[i] <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_send_valid <= 1'b0;
                r_send_item  <= '0;
            end
            unique case (i_cmd.op)
                OP_POLL: begin
                    r_phase <= PH_POLL;
                    if (w_poll_ok) begin
                        r_last_poll <= r_now;
                        r_phase     <= PH_ID;
                    end
                end
                OP_ECHO: begin
                    if (r_echo_left <= 8'd1) begin
                        r_echo_left <= '0;
                        r_phase     <= PH_POLL;
                    end else begin
                        r_echo_left <= r_echo_left - 8'd1;
                    end
                end
                OP_ID: begin
                    r_phase <= PH_POLL;
                    if (o_sts.id_match) begin
                        if (r_pending_flag) r_item_sent[w_pend_addr] <= r_now;
                        if (w_do_send) begin
                            r_send_valid <= 1'b1;
                            r_send_item  <= r_pending_index;
                        end
                        r_echo_left <= n_echo_left;
                        if (r_echo_skip && n_echo_left != 8'd0) r_phase <= PH_ECHO;
                        r_pending_flag  <= 1'b0;
                        r_pending_index <= '0;
                        r_scan          <= '0;
                    end
                end
                OP_SCAN: begin
                    if (w_scan_hit) begin
                        r_pending_flag        <= 1'b1;
                        r_pending_index       <= w_scan_idx;
                        r_item_round[r_scan]  <= r_round;
                    end else if (r_scan == LAST_IDX) begin
                        r_round <= r_round + 16'd1;
                    end else begin
                        r_scan <= r_scan + IW'(1);
                    end
                end
                default: ;
            endcase
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SENSOR_ID: r_sensor_id <= i_cfg_wdata[7:0];
                    CFG_ECHO_SKIP: begin
                        r_echo_skip <= i_cfg_wdata[0];
                        if (!i_cfg_wdata[0]) r_echo_left <= '0;
                    end
                    CFG_MIN_GAP:   r_min_gap <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) r_m_tvalid <= 1'b1;
            else if (i_m_tready) r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_rx_byte <= i_s_tdata[7:0];
            r_now     <= TIME_BITS'(i_s_tdata[39:8]);
            r_avail   <= i_s_tdata[63:40];
            r_ok      <= i_s_tdata[64];
            r_flen    <= i_s_tdata[69:65];
        end
        if (i_cmd.load_out) begin
            r_m_tdata <= {2'b00, r_phase, w_pend_out, r_pending_flag, r_send_item, r_send_valid};
        end
    end

    `TPRS_ASSERT_HOLDS(a_echo_off_empty, i_clk, i_rst_n, r_echo_skip || (r_echo_left == 8'd0))
    `TPRS_ASSERT_HOLDS(a_pending_marked, i_clk, i_rst_n, !r_pending_flag || (r_item_round[w_pend_addr] == r_round))
    `TPRS_ASSERT_NEXT(a_hit_schedules, i_clk, i_rst_n, (i_cmd.op == OP_SCAN) && w_scan_hit, r_pending_flag)
    `TPRS_ASSERT_NEXT(a_echo_not_id, i_clk, i_rst_n, i_cmd.op == OP_ECHO, r_phase != PH_ID)

endmodule

// ===== tb/telemetry_poll_responder_scheduler_tb.sv =====
// Self-checking bench for the poll responder: drives received bus bytes, predicts every
// response beat in-line and checks it field by field. Depends on tprs_pkg and the top level.
`timescale 1ns / 1ps

module telemetry_poll_responder_scheduler_tb;
    import tprs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int N_ITEMS = 24;

    // one received byte as packed on i_s_tdata, rx_byte lowest
    typedef struct packed {
        logic [4:0]  flen;
        logic        ok;
        logic [23:0] mask;
        logic [31:0] now;
        logic [7:0]  rx;
    } t_rx_beat;

    // one response as packed on o_m_tdata[13:0], send_valid lowest
    typedef struct packed {
        logic [1:0] phase;
        logic [4:0] pend_item;
        logic       pend;
        logic [4:0] sent_item;
        logic       sent;
    } t_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire [OUT_DATA_W-1:0]  o_m_tdata;

    telemetry_poll_responder_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // responder registers and state as the bench sees them
    logic [7:0]  id_cfg;
    logic        skip_cfg;
    logic [15:0] gap_cfg;
    logic [1:0]  ph;
    logic [7:0]  echo_cnt;
    logic [31:0] poll_stamp;
    logic [4:0]  sched_idx;
    logic        sched_on;
    logic [15:0] round_ctr;
    logic [31:0] stamp    [N_ITEMS];
    logic [15:0] round_of [N_ITEMS];

    t_reply      replies_due [$];
    logic [31:0] t_now = '0;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          errors = 0;
    int          n_bytes = 0;
    int          n_replies = 0;
    int          n_sends = 0;
    int          n_sched = 0;
    int          n_writes = 0;

    function automatic int unsigned item_period_ms(input int idx);
        case (idx)
            3:                      return 300;
            4, 5, 6, 7, 8, 9:       return 850;
            10, 21:                 return 2000;
            11, 22:                 return 1500;
            12:                     return 600;
            18:                     return 750;
            19:                     return 200;
            20:                     return 8000;
            default:                return 100;
        endcase
    endfunction

    task automatic reset_model();
        id_cfg     = 8'd27;
        skip_cfg   = 1'b1;
        gap_cfg    = 16'd10000;
        ph         = PH_POLL;
        echo_cnt   = '0;
        poll_stamp = '0;
        sched_idx  = '0;
        sched_on   = 1'b0;
        round_ctr  = 16'd1;
        for (int i = 0; i < N_ITEMS; i++) begin
            stamp[i]    = '0;
            round_of[i] = '0;
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SENSOR_ID: id_cfg = val[7:0];
            CFG_ECHO_SKIP: begin
                skip_cfg = val[0];
                if (!skip_cfg) echo_cnt = '0;
            end
            CFG_MIN_GAP:   gap_cfg = val;
            default: ;
        endcase
    endtask

    // pick the lowest due, available item not yet taken this round
    task automatic schedule_scan(input logic [31:0] now, input logic [23:0] mask);
        logic [31:0] dt;
        sched_on  = 1'b0;
        sched_idx = '0;
        for (int i = 0; i < N_ITEMS; i++) begin
            dt = now - stamp[i];
            if (!sched_on && mask[i] && round_of[i] != round_ctr &&
                dt > item_period_ms(i) * 1000) begin
                sched_on    = 1'b1;
                sched_idx   = i[4:0];
                round_of[i] = round_ctr;
            end
        end
        if (!sched_on) round_ctr = round_ctr + 16'd1;
    endtask

    task automatic respond_to_byte(input t_rx_beat bt, output t_reply r);
        logic [31:0] dt;
        logic [8:0]  sum;
        r = '0;
        case (ph)
            PH_ECHO: begin
                if (echo_cnt <= 8'd1) begin
                    echo_cnt = '0;
                    ph = PH_POLL;
                end else begin
                    echo_cnt = echo_cnt - 8'd1;
                end
            end
            PH_ID: begin
                ph = PH_POLL;
                if (bt.rx == id_cfg) begin
                    if (sched_on) begin
                        stamp[sched_idx] = bt.now;
                        if (bt.ok) begin
                            r.sent      = 1'b1;
                            r.sent_item = sched_idx;
                            n_sends++;
                            if (skip_cfg) begin
                                sum = {1'b0, echo_cnt} + {4'd0, bt.flen};
                                echo_cnt = (sum > 9'd255) ? 8'd255 : sum[7:0];
                            end else begin
                                echo_cnt = '0;
                            end
                        end
                    end
                    if (skip_cfg && echo_cnt != 8'd0) ph = PH_ECHO;
                    schedule_scan(bt.now, bt.mask);
                end
            end
            default: begin
                ph = PH_POLL;
                dt = bt.now - poll_stamp;
                if (bt.rx == POLL_BYTE && dt > {16'd0, gap_cfg}) begin
                    poll_stamp = bt.now;
                    ph = PH_ID;
                end
            end
        endcase
        r.pend      = sched_on;
        r.pend_item = sched_on ? sched_idx : 5'd0;
        r.phase     = ph;
        if (sched_on) n_sched++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR reply %0d: %s", n_replies, msg);
        errors++;
    endtask

    // send one byte; valid stays high after the beat so the next one may follow at once
    task automatic send_rx(input logic [7:0] b, input logic [31:0] t, input logic [23:0] m,
                           input logic ok, input logic [4:0] fl);
        t_rx_beat bt;
        t_reply   r;
        bt = '{flen: fl, ok: ok, mask: m, now: t, rx: b};
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        respond_to_byte(bt, r);
        replies_due.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bt};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_bytes++;
    endtask

    // drop valid and wait until every response is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        n_writes++;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] id, input logic skip, input logic [15:0] gap);
        settle();
        write_reg(CFG_SENSOR_ID, {8'd0, id});
        write_reg(CFG_ECHO_SKIP, {15'd0, skip});
        write_reg(CFG_MIN_GAP, gap);
    endtask

    function automatic logic [23:0] rand_mask();
        case ($urandom_range(0, 9))
            0:       return 24'hffffff;
            1:       return 24'h000000;
            2:       return 24'h1 << $urandom_range(0, 23);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] rand_flen();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 6));
    endfunction

    // poll, id, echo exchanges with random content, some noise and broken ones
    task automatic run_exchanges(input int goal);
        int          start;
        logic [7:0]  idb;
        start = n_bytes;
        while (n_bytes - start < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                t_now = t_now + $urandom_range(0, 5000);
                send_rx(8'($urandom), t_now, rand_mask(), 1'($urandom), 5'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0:       t_now = poll_stamp + gap_cfg;
                    1:       t_now = poll_stamp + gap_cfg + 32'd1;
                    2:       t_now = $urandom;
                    3:       t_now = t_now + $urandom_range(1000000, 9000000);
                    default: t_now = t_now + $urandom_range(0, 150000);
                endcase
                send_rx(POLL_BYTE, t_now, rand_mask(), 1'($urandom), 5'($urandom));
                if (ph == PH_ID) begin
                    t_now = t_now + $urandom_range(100, 2000);
                    idb = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_cfg;
                    send_rx(idb, t_now, rand_mask(), $urandom_range(0, 7) != 0, rand_flen());
                    while (ph == PH_ECHO) begin
                        t_now = t_now + $urandom_range(50, 200);
                        send_rx(8'($urandom), t_now, rand_mask(), 1'($urandom), 5'($urandom));
                    end
                end
            end
        end
    endtask

    task automatic test_directed_cases();
        send_rx(8'h00, 32'd0, 24'h000000, 1'b0, 5'd0);
        send_rx(8'hff, 32'hffffffff, 24'hffffff, 1'b1, 5'd31);
        send_rx(POLL_BYTE, 32'd10000, 24'hffffff, 1'b1, 5'd1);
        send_rx(POLL_BYTE, 32'd10001, 24'hffffff, 1'b1, 5'd1);
        send_rx(8'h1a, 32'd10002, 24'hffffff, 1'b1, 5'd1);
        send_rx(POLL_BYTE, 32'd20002, 24'hffffff, 1'b1, 5'd1);
        send_rx(8'd27, 32'd20003, 24'hffffff, 1'b1, 5'd5);
        send_rx(POLL_BYTE, 32'h80000000, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h80000001, 24'hffffff, 1'b1, 5'd9);
        send_rx(POLL_BYTE, 32'h80004e20, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h80004e21, 24'hffffff, 1'b1, 5'd3);
        // echoes, one of them looking like a poll
        send_rx(POLL_BYTE, 32'h80004e30, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'h00, 32'h80004e40, 24'h000000, 1'b0, 5'd0);
        send_rx(8'hff, 32'h80004e50, 24'hffffff, 1'b1, 5'd31);
        // failed encoding: restamp only
        send_rx(POLL_BYTE, 32'h80009c40, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h80009c41, 24'hffffff, 1'b0, 5'd31);
        send_rx(POLL_BYTE, 32'h8000ea60, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h8000ea61, 24'hffffff, 1'b1, 5'd0);
        send_rx(POLL_BYTE, 32'h80013880, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h80013881, 24'hffffff, 1'b1, 5'd4);
        // echo skip cleared while skipping: next byte leaves with an empty counter
        settle();
        write_reg(CFG_ECHO_SKIP, '0);
        send_rx(POLL_BYTE, 32'h80013890, 24'hffffff, 1'b1, 5'd0);
        send_rx(POLL_BYTE, 32'h800186a0, 24'hffffff, 1'b1, 5'd0);
        send_rx(8'd27, 32'h800186a1, 24'h000000, 1'b1, 5'd31);
        settle();
        write_reg(CFG_ECHO_SKIP, 16'd1);
    endtask

    task automatic test_default_regs();
        set_regs(8'd27, 1'b1, 16'd10000);
        run_exchanges(100);
    endtask

    task automatic test_low_regs();
        set_regs(8'h00, 1'b1, 16'h0000);
        run_exchanges(90);
    endtask

    task automatic test_high_regs();
        set_regs(8'hff, 1'b0, 16'hffff);
        write_reg(CFG_UNUSED, 16'hffff);
        run_exchanges(90);
    endtask

    task automatic test_id_is_poll_byte();
        set_regs(POLL_BYTE, 1'b1, 16'd500);
        run_exchanges(80);
    endtask

    task automatic test_random_regs();
        repeat (2) begin
            set_regs(8'($urandom), 1'($urandom), 16'($urandom));
            run_exchanges(50);
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        set_regs(8'd27, 1'b1, 16'd10000);
        run_exchanges(70);
    endtask

    always @(posedge i_clk) begin : reply_check
        t_reply got;
        t_reply want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata[13:0];
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", o_m_tdata));
            end else begin
                want = replies_due.pop_front();
                if (got.sent !== want.sent)
                    report_mismatch($sformatf("send_valid %b want %b", got.sent, want.sent));
                if (got.sent_item !== want.sent_item)
                    report_mismatch($sformatf("send_item %0d want %0d",
                                              got.sent_item, want.sent_item));
                if (got.pend !== want.pend)
                    report_mismatch($sformatf("pending_valid %b want %b", got.pend, want.pend));
                if (got.pend_item !== want.pend_item)
                    report_mismatch($sformatf("pending_item %0d want %0d",
                                              got.pend_item, want.pend_item));
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d want %0d", got.phase, want.phase));
            end
            n_replies++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_default_regs();
        test_low_regs();
        test_high_regs();
        test_id_is_poll_byte();
        test_random_regs();
        test_back_to_back();
        settle();
        repeat (30) @(posedge i_clk);
        $display("covered %0d bus bytes, %0d register writes", n_bytes, n_writes);
        $display("replies checked %0d: %0d send orders, %0d with an item scheduled",
                 n_replies, n_sends, n_sched);
        if (errors == 0) begin
            $display("telemetry_poll_responder_scheduler: match");
        end else begin
            $display("telemetry_poll_responder_scheduler: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d replies outstanding", replies_due.size());
        $display("telemetry_poll_responder_scheduler: mismatch");
        $finish;
    end

endmodule
